>>> rtl/core/mpss_pkg.sv
// shared constants, types and the sequencer state encoding for the matrix product core
package mpss_pkg;

  localparam int DIM_DEF        = 256;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int SIZE_W         = 9;
  localparam int IDX_W          = 8;
  localparam int TRUNC_BITS     = 16;
  localparam int SUM_W          = 64;

  localparam logic REG_SIZE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } sq_ctl_t;

endpackage

>>> rtl/core/matrix_product_sum_of_squares_core.sv
// top level: element stores, product sequencer, multiply-accumulate and result port
//
// Load words (no last flag) are taken one per cycle and write one element of A and of B.
// A word with the last flag writes its pair, then the block walks C = A*B entry by entry
// with one multiply-accumulate per cycle, reading one A and one B element from the two
// element memories each cycle, a pace set by the single read port of each memory. No word
// is taken during the computation. The result sits in an output register; load words are
// taken while it waits, and a further computation finishes into the register only once
// the previous result has been taken.
module matrix_product_sum_of_squares_core import mpss_pkg::*; #(
  parameter int DIM        = DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IDX_W-1:0]      row,
  input  logic [IDX_W-1:0]      col,
  input  logic [ELEM_WIDTH-1:0] a_elem,
  input  logic [ELEM_WIDTH-1:0] b_elem,
  input  logic                  last_element,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUM_W-1:0]      sum_of_squares,
  output logic                  saturated
);

  localparam int IW     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW     = $clog2(DIM * DIM);
  localparam int ACC_RAW = 2 * ELEM_WIDTH + IW + 1;
  localparam int ACC_W  = (ACC_RAW > 64) ? 64 : ACC_RAW;
  localparam int DEPTH  = DIM * DIM;

  state_t state;
  logic [SIZE_W-1:0] size_reg;
  logic [IW-1:0] nm1, ci, cj, ck;

  logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];
  logic signed [ELEM_WIDTH-1:0] rd_a, rd_b;

  logic in_fire, in_range, wr_en, cfg_wr;
  logic [AW-1:0] wr_addr, ra_a, ra_b;
  logic [IW-1:0] n_m1_next;
  logic k_end, j_end, i_end;

  logic v1, first1, lastk1, all1;
  logic v2, first2, lastk2, all2;
  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic signed [ACC_W-1:0] acc, acc_sum, entry;
  sq_ctl_t ctl_entry;
  logic sq_done;
  logic [SUM_W-1:0] sum_q;
  logic sat_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SIZE) ? 32'(size_reg) : 32'b0;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_range = (32'(row) < DIM) && (32'(col) < DIM);
  assign wr_en    = in_fire && in_range;
  assign wr_addr  = AW'(32'(row) * DIM + 32'(col));
  assign ra_a     = AW'(32'(ci) * DIM + 32'(ck));
  assign ra_b     = AW'(32'(ck) * DIM + 32'(cj));

  assign k_end = (ck == nm1);
  assign j_end = (cj == nm1);
  assign i_end = (ci == nm1);

  always_comb begin
    priority if (size_reg == '0) begin
      n_m1_next = '0;
    end else if (32'(size_reg) > DIM) begin
      n_m1_next = IW'(DIM - 1);
    end else begin
      n_m1_next = IW'(size_reg - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= signed'(a_elem);
      mem_b[wr_addr] <= signed'(b_elem);
    end
    rd_a <= mem_a[ra_a];
    rd_b <= mem_b[ra_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_W'(DIM);
    end else if (cfg_wr && paddr[2] == REG_SIZE) begin
      size_reg <= pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ci <= '0;
      cj <= '0;
      ck <= '0;
      nm1 <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && last_element) begin
            nm1   <= n_m1_next;
            ci    <= '0;
            cj    <= '0;
            ck    <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k_end) begin
            ck <= '0;
            if (j_end) begin
              cj <= '0;
              ci <= ci + 1'b1;
            end else begin
              cj <= cj + 1'b1;
            end
          end else begin
            ck <= ck + 1'b1;
          end
          if (k_end && j_end && i_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (sq_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && (!out_valid || out_ready)) begin
      sum_of_squares <= sum_q;
      saturated      <= sat_q;
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ctl_entry <= '0;
    end else begin
      v1 <= (state == ST_RUN);
      v2 <= v1;
      ctl_entry.valid <= v2 && lastk2;
      ctl_entry.last  <= all2;
    end
  end

  assign acc_sum = first2 ? ACC_W'(prod) : acc + ACC_W'(prod);

  always_ff @(posedge clk) begin
    first1 <= (ck == '0);
    lastk1 <= k_end;
    all1   <= k_end && j_end && i_end;
    first2 <= first1;
    lastk2 <= lastk1;
    all2   <= all1;
    prod   <= rd_a * rd_b;
    if (v2) begin
      acc <= acc_sum;
    end
    if (v2 && lastk2) begin
      entry <= acc_sum;
    end
  end

  mpss_sqacc #(
    .ACC_W(ACC_W)
  ) u_sqacc (
    .clk    (clk),
    .rst    (rst),
    .clear  (in_fire && last_element),
    .ctl_in (ctl_entry),
    .entry  (entry),
    .done   (sq_done),
    .sum    (sum_q),
    .sat    (sat_q)
  );

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("word accepted during computation");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == ST_DRAIN))
    else $error("sum finished outside drain");

  a_pipe_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !v1)
    else $error("product pipeline active while idle");

  a_hold_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && !out_valid) |=> out_valid)
    else $error("result not loaded");

endmodule

>>> rtl/core/mpss_sqacc.sv
// truncation, squaring and saturating accumulation of finished product entries
module mpss_sqacc import mpss_pkg::*; #(
  parameter int ACC_W = 41
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  sq_ctl_t                 ctl_in,
  input  logic signed [ACC_W-1:0] entry,
  output logic                    done,
  output logic [SUM_W-1:0]        sum,
  output logic                    sat
);

  localparam int MAG_W = ACC_W - TRUNC_BITS;

  logic signed [MAG_W-1:0] shifted;
  logic [MAG_W-1:0]        mag;
  logic [31:0]             mag32;
  logic                    mag_big;
  sq_ctl_t                 ctl_mag;
  logic [63:0]             sq;
  logic                    sq_big;
  sq_ctl_t                 ctl_sq;
  logic [SUM_W:0]          total;

  assign shifted = MAG_W'(entry >>> TRUNC_BITS);
  assign mag32   = 32'(mag);
  assign total   = (SUM_W+1)'(sum) + (SUM_W+1)'(sq);

  always_ff @(posedge clk) begin
    if (shifted[MAG_W-1]) begin
      mag <= MAG_W'(-shifted);
    end else begin
      mag <= MAG_W'(shifted);
    end
    sq      <= 64'(mag32) * 64'(mag32);
    sq_big  <= mag_big;
  end

  always_comb begin
    mag_big = 1'b0;
    if (MAG_W > 32) begin
      mag_big = |(64'(mag) >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mag <= '0;
      ctl_sq  <= '0;
      done    <= 1'b0;
      sum     <= '0;
      sat     <= 1'b0;
    end else begin
      ctl_mag <= ctl_in;
      ctl_sq  <= ctl_mag;
      done    <= ctl_sq.valid && ctl_sq.last;
      if (clear) begin
        sum <= '0;
        sat <= 1'b0;
      end else if (ctl_sq.valid) begin
        if (sq_big || total[SUM_W]) begin
          sum <= '1;
          sat <= 1'b1;
        end else begin
          sum <= total[SUM_W-1:0];
        end
      end
    end
  end

endmodule
